[design/mpsp_pkg.sv]
// Shared types, constants and the control program of the modular power and split product block.
package mpsp_pkg;

   // Width of the modulus and of every residue inside the datapath.
   localparam int MOD_BITS    = 31;
   // The serial unit walks one bit per cycle over a dividend one bit wider than a residue.
   localparam int SU_STEPS    = MOD_BITS + 1;
   localparam int SU_CNT_BITS = $clog2(SU_STEPS);

   localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

   localparam int STEP_BITS = 5;
   typedef logic [STEP_BITS-1:0] step_type;

   // Jump targets in the control program.
   localparam step_type S_POW_TEST = STEP_BITS'(3);
   localparam step_type S_POW_SQR  = STEP_BITS'(6);
   localparam step_type S_POW_FIN  = STEP_BITS'(7);
   localparam step_type S_SPLIT    = STEP_BITS'(8);
   localparam step_type S_P1_TEST  = STEP_BITS'(12);
   localparam step_type S_P1_SQR   = STEP_BITS'(15);
   localparam step_type S_P2_LOAD  = STEP_BITS'(16);
   localparam step_type S_P2_TEST  = STEP_BITS'(18);
   localparam step_type S_P2_SQR   = STEP_BITS'(21);
   localparam step_type S_COMBINE  = STEP_BITS'(22);
   localparam step_type S_ERR      = STEP_BITS'(24);
   localparam step_type S_LAST     = STEP_BITS'(24);

   typedef enum logic [2:0] {
      UOP_NONE,
      UOP_DIV_AB,
      UOP_MOD_BASE,
      UOP_MUL_ACC_SQ,
      UOP_MUL_SQ_SQ,
      UOP_MUL_HOLD_ACC
   } uop_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LD_POW,
      ACT_LD_P1,
      ACT_LD_P2,
      ACT_SHIFT
   } act_type;

   typedef enum logic [2:0] {
      CND_NEXT,
      CND_GOTO,
      CND_SPLIT,
      CND_B_ZERO,
      CND_EXP_ZERO,
      CND_EXP_EVEN,
      CND_FIN_OK,
      CND_FIN_ERR
   } cnd_type;

   typedef struct packed {
      uop_type  uop;
      act_type  act;
      cnd_type  cnd;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } su_req_type;

   // Control store. The action and the jump of a word take effect when the word
   // completes: at once for a word without a unit operation, else when the unit is done.
   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type w;
      w = '{uop: UOP_NONE, act: ACT_NONE, cnd: CND_NEXT, target: '0};
      case (step)
         // Dispatch, then the power program.
         STEP_BITS'(0): begin w.cnd = CND_SPLIT; w.target = S_SPLIT; end
         STEP_BITS'(1): begin w.act = ACT_LD_POW; end
         STEP_BITS'(2): begin w.uop = UOP_MOD_BASE; end
         STEP_BITS'(3): begin w.cnd = CND_EXP_ZERO; w.target = S_POW_FIN; end
         STEP_BITS'(4): begin w.cnd = CND_EXP_EVEN; w.target = S_POW_SQR; end
         STEP_BITS'(5): begin w.uop = UOP_MUL_ACC_SQ; end
         STEP_BITS'(6): begin
            w.uop = UOP_MUL_SQ_SQ; w.act = ACT_SHIFT; w.cnd = CND_GOTO; w.target = S_POW_TEST;
         end
         STEP_BITS'(7): begin w.cnd = CND_FIN_OK; end
         // Split program: quotient and remainder, then two powers and their product.
         STEP_BITS'(8): begin w.cnd = CND_B_ZERO; w.target = S_ERR; end
         STEP_BITS'(9): begin w.uop = UOP_DIV_AB; end
         STEP_BITS'(10): begin w.act = ACT_LD_P1; end
         STEP_BITS'(11): begin w.uop = UOP_MOD_BASE; end
         STEP_BITS'(12): begin w.cnd = CND_EXP_ZERO; w.target = S_P2_LOAD; end
         STEP_BITS'(13): begin w.cnd = CND_EXP_EVEN; w.target = S_P1_SQR; end
         STEP_BITS'(14): begin w.uop = UOP_MUL_ACC_SQ; end
         STEP_BITS'(15): begin
            w.uop = UOP_MUL_SQ_SQ; w.act = ACT_SHIFT; w.cnd = CND_GOTO; w.target = S_P1_TEST;
         end
         STEP_BITS'(16): begin w.act = ACT_LD_P2; end
         STEP_BITS'(17): begin w.uop = UOP_MOD_BASE; end
         STEP_BITS'(18): begin w.cnd = CND_EXP_ZERO; w.target = S_COMBINE; end
         STEP_BITS'(19): begin w.cnd = CND_EXP_EVEN; w.target = S_P2_SQR; end
         STEP_BITS'(20): begin w.uop = UOP_MUL_ACC_SQ; end
         STEP_BITS'(21): begin
            w.uop = UOP_MUL_SQ_SQ; w.act = ACT_SHIFT; w.cnd = CND_GOTO; w.target = S_P2_TEST;
         end
         STEP_BITS'(22): begin w.uop = UOP_MUL_HOLD_ACC; end
         STEP_BITS'(23): begin w.cnd = CND_FIN_OK; end
         STEP_BITS'(24): begin w.cnd = CND_FIN_ERR; end
         default: begin w.cnd = CND_FIN_ERR; end
      endcase
      return w;
   endfunction

endpackage

[design/mpsp_serial_unit.sv]
// Bit-serial divider and modular multiplier shared by every division and modular multiplication of the control program.
module mpsp_serial_unit
   import mpsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  su_req_type          su_req,
   input  logic [SU_STEPS-1:0] opnd_x,
   input  logic [MOD_BITS-1:0] opnd_y,
   input  logic [MOD_BITS-1:0] modulus,
   output logic                done,
   output logic [SU_STEPS-1:0] quotient,
   output logic [MOD_BITS-1:0] remainder
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   div_ff, div_in;
   logic [SU_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SU_STEPS-1:0]    sh_ff, sh_in;
   logic [MOD_BITS-1:0]    rem_ff, rem_in;
   logic [MOD_BITS-1:0]    opd_ff, opd_in;

   logic [SU_STEPS-1:0] trial;
   logic [SU_STEPS-1:0] trial_diff;
   logic                trial_ge;
   logic [SU_STEPS-1:0] mod_ext;
   logic [SU_STEPS-1:0] dbl;
   logic [SU_STEPS-1:0] dbl_red;
   logic [SU_STEPS-1:0] sum;
   logic [SU_STEPS-1:0] sum_red;
   logic                last_step;

   assign mod_ext   = SU_STEPS'(modulus);
   assign last_step = (cnt_ff == SU_CNT_BITS'(SU_STEPS - 1));

   // Restoring division: one quotient bit per cycle.
   assign trial      = {rem_ff, sh_ff[SU_STEPS-1]};
   assign trial_ge   = (trial >= SU_STEPS'(opd_ff));
   assign trial_diff = trial - SU_STEPS'(opd_ff);

   // Interleaved modular multiplication: double, reduce, add, reduce. Both
   // the running residue and the multiplicand stay below the modulus.
   assign dbl     = {rem_ff, 1'b0};
   assign dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
   assign sum     = dbl_red + (sh_ff[SU_STEPS-1] ? SU_STEPS'(opd_ff) : '0);
   assign sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      opd_in  = opd_ff;
      if (su_req.start) begin
         busy_in = 1'b1;
         div_in  = su_req.is_div;
         cnt_in  = '0;
         rem_in  = '0;
         sh_in   = su_req.is_div ? opnd_x : SU_STEPS'(opnd_y);
         opd_in  = su_req.is_div ? opnd_y : opnd_x[MOD_BITS-1:0];
      end else if (busy_ff) begin
         cnt_in = cnt_ff + SU_CNT_BITS'(1);
         if (div_ff) begin
            rem_in = trial_ge ? trial_diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];
            sh_in  = {sh_ff[SU_STEPS-2:0], trial_ge};
         end else begin
            rem_in = sum_red[MOD_BITS-1:0];
            sh_in  = {sh_ff[SU_STEPS-2:0], 1'b0};
         end
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      opd_ff <= opd_in;
   end

   assign done      = done_ff;
   assign quotient  = sh_ff;
   assign remainder = rem_ff;

endmodule

[design/modular_power_and_split_product.sv]
// Modular power and split product: sequencer, datapath registers and result register.
//
// Requests enter on the req_ channel (valid/ready) and one result per request leaves on
// the rsp_ channel. req_type 0 asks for operand_a to the power operand_b modulo the
// modulus; req_type 1 splits the total operand_a into operand_b parts and returns
// q^(b-r) * (q+1)^r modulo the modulus. Zero parts gives result_error with value 0.
// The modulus is written through csr_write_enable/csr_write_data; the user must do so
// only while the block is idle, as the block itself does not enforce it. One request is
// worked at a time. Every division and modular multiplication runs on one shared
// bit-serial unit, from issue through the serial steps to write-back. Steps without a
// unit operation are walked one step per cycle, but a final step waits until the
// result register frees.
// Reset idles the sequencer, empties the result register and sets the modulus to
// 1000000007. A finished result sits in the output register; a new request is taken
// while it waits, and a later result waits at its final step until that register frees.
module modular_power_and_split_product
   import mpsp_pkg::*;
#(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [VALUE_BITS-1:0] req_operand_a,
   input  logic [VALUE_BITS-1:0] req_operand_b,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_result_value,
   output logic                  rsp_result_error,
   input  logic                  csr_write_enable,
   input  logic [MOD_BITS-1:0]   csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   step_type            step_ff, step_in;
   logic [MOD_BITS-1:0] modulus_ff, modulus_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                rsp_error_ff, rsp_error_in;

   logic                kind_ff, kind_in;
   logic [MOD_BITS-1:0] a_ff, a_in;
   logic [MOD_BITS-1:0] b_ff, b_in;
   logic [SU_STEPS-1:0] base_ff, base_in;
   logic [MOD_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] sq_ff, sq_in;
   logic [MOD_BITS-1:0] hold_ff, hold_in;
   logic [MOD_BITS-1:0] q_ff, q_in;
   logic [MOD_BITS-1:0] r_ff, r_in;

   ctrl_word_type       word;
   logic [MOD_BITS-1:0] mod_eff;
   logic                uses_unit;
   logic                is_fin;
   logic                out_free;
   logic                complete;
   logic                jump;
   logic                fin_load;
   step_type            step_next;

   su_req_type          su_req;
   logic [SU_STEPS-1:0] su_x;
   logic [MOD_BITS-1:0] su_y;
   logic                su_done;
   logic [SU_STEPS-1:0] su_quo;
   logic [MOD_BITS-1:0] su_rem;

   assign word      = ucode(step_ff);
   // A modulus of zero behaves as a modulus of one.
   assign mod_eff   = (modulus_ff == '0) ? MOD_BITS'(1) : modulus_ff;
   assign uses_unit = (word.uop != UOP_NONE);
   assign is_fin    = (word.cnd == CND_FIN_OK) || (word.cnd == CND_FIN_ERR);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign complete  = ((state_ff == ST_EXEC) && !uses_unit) || ((state_ff == ST_WAIT) && su_done);
   assign fin_load  = (state_ff == ST_EXEC) && is_fin && out_free;
   assign step_next = jump ? word.target : (step_ff + STEP_BITS'(1));

   always_comb begin
      case (word.cnd)
         CND_NEXT:     jump = 1'b0;
         CND_GOTO:     jump = 1'b1;
         CND_SPLIT:    jump = kind_ff;
         CND_B_ZERO:   jump = (b_ff == '0);
         CND_EXP_ZERO: jump = (exp_ff == '0);
         CND_EXP_EVEN: jump = !exp_ff[0];
         default:      jump = 1'b0;
      endcase
   end

   // Unit request and operand selection.
   always_comb begin
      su_req.start  = (state_ff == ST_EXEC) && uses_unit;
      su_req.is_div = (word.uop == UOP_DIV_AB) || (word.uop == UOP_MOD_BASE);
      case (word.uop)
         UOP_DIV_AB: begin
            su_x = SU_STEPS'(a_ff);
            su_y = b_ff;
         end
         UOP_MOD_BASE: begin
            su_x = base_ff;
            su_y = mod_eff;
         end
         UOP_MUL_ACC_SQ: begin
            su_x = SU_STEPS'(sq_ff);
            su_y = acc_ff;
         end
         UOP_MUL_SQ_SQ: begin
            su_x = SU_STEPS'(sq_ff);
            su_y = sq_ff;
         end
         UOP_MUL_HOLD_ACC: begin
            su_x = SU_STEPS'(hold_ff);
            su_y = acc_ff;
         end
         default: begin
            su_x = '0;
            su_y = '0;
         end
      endcase
   end

   mpsp_serial_unit u_serial (
      .clock     (clock),
      .reset     (reset),
      .su_req    (su_req),
      .opnd_x    (su_x),
      .opnd_y    (su_y),
      .modulus   (mod_eff),
      .done      (su_done),
      .quotient  (su_quo),
      .remainder (su_rem)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
               step_in  = '0;
            end
         end
         ST_EXEC: begin
            if (uses_unit) begin
               state_in = ST_WAIT;
            end else if (is_fin) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               step_in = step_next;
            end
         end
         ST_WAIT: begin
            if (su_done) begin
               state_in = ST_EXEC;
               step_in  = step_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath registers and the result register.
   always_comb begin
      modulus_in   = csr_write_enable ? csr_write_data : modulus_ff;
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      hold_in      = hold_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;

      if ((state_ff == ST_IDLE) && req_valid) begin
         kind_in = req_type;
         a_in    = MOD_BITS'(req_operand_a);
         b_in    = MOD_BITS'(req_operand_b);
      end

      if ((state_ff == ST_WAIT) && su_done) begin
         case (word.uop)
            UOP_DIV_AB: begin
               q_in = su_quo[MOD_BITS-1:0];
               r_in = su_rem;
            end
            UOP_MOD_BASE:     sq_in  = su_rem;
            UOP_MUL_ACC_SQ:   acc_in = su_rem;
            UOP_MUL_SQ_SQ:    sq_in  = su_rem;
            UOP_MUL_HOLD_ACC: acc_in = su_rem;
            default: begin
            end
         endcase
      end

      if (complete) begin
         case (word.act)
            ACT_LD_POW: begin
               base_in = SU_STEPS'(a_ff);
               exp_in  = b_ff;
               acc_in  = MOD_BITS'(1);
            end
            ACT_LD_P1: begin
               base_in = SU_STEPS'(q_ff);
               exp_in  = b_ff - r_ff;
               acc_in  = MOD_BITS'(1);
            end
            ACT_LD_P2: begin
               // The first power is parked while the second one is formed.
               hold_in = acc_ff;
               base_in = SU_STEPS'(q_ff) + SU_STEPS'(1);
               exp_in  = r_ff;
               acc_in  = MOD_BITS'(1);
            end
            ACT_SHIFT: exp_in = exp_ff >> 1;
            default: begin
            end
         endcase
      end

      if (fin_load) begin
         rsp_valid_in = 1'b1;
         rsp_error_in = (word.cnd == CND_FIN_ERR);
         rsp_value_in = (word.cnd == CND_FIN_ERR) ? '0 : acc_ff[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         modulus_ff   <= MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      base_ff      <= base_in;
      exp_ff       <= exp_in;
      acc_ff       <= acc_in;
      sq_ff        <= sq_in;
      hold_ff      <= hold_in;
      q_ff         <= q_in;
      r_ff         <= r_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_error = rsp_error_ff;

   // An error result always carries a zero value.
   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_error) |-> (rsp_result_value == '0))
      else $error("error result with nonzero value");

   // The serial unit is started only from an executing step.
   a_start_in_exec: assert property (@(posedge clock) disable iff (reset)
      su_req.start |-> (state_ff == ST_EXEC))
      else $error("unit started outside an executing step");

   // The unit reports completion only while the sequencer waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      su_done |-> (state_ff == ST_WAIT))
      else $error("unit done while sequencer not waiting");

   // The step counter never leaves the program.
   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (step_ff <= S_LAST))
      else $error("step counter beyond end of program");

   // An accepted item starts the program at its first step.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ((state_ff == ST_EXEC) && (step_ff == '0)))
      else $error("accepted item did not start the program");

endmodule
